// ===== rtl/sha_pkg.sv =====
// sha-256 shared types, constants and round functions
// no dependencies
package sha_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds = 64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_LOAD,
		ST_SCHED,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic        start;
		logic        is_final;
	} comp_ctl_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== rtl/sha_core.sv =====
// sha-256 compression unit: block buffer memory, 16-word schedule window, one round per cycle
// depends on sha_pkg
module sha_core (
	input  logic                clk,
	input  logic                arst_n,
	// buffer write port
	input  logic                wr_en,
	input  logic [5:0]          wr_addr,
	input  logic [7:0]          wr_data,
	input  sha_pkg::comp_ctl_t  ctl,
	output logic                busy,
	output logic                done,
	output logic [255:0]        hash
);
	import sha_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_LOAD, C_RUN, C_FOLD} cst_t;

	logic [7:0]   buf_mem [BlockBytes];
	logic [7:0]   rd_data_q;
	logic [5:0]   rd_addr;
	cst_t         cst_q;
	logic [6:0]   ld_q;
	logic [5:0]   rnd_q;
	logic [31:0]  w_q [16];
	logic [31:0]  v_q [8];
	logic [31:0]  h_q [8];
	logic         clr_q;
	logic [31:0]  sig0, sig1, w_new, wt, t1, t2, e, a;

	// byte buffer memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			buf_mem[wr_addr] <= wr_data;
		rd_data_q <= buf_mem[rd_addr];
	end

	assign rd_addr = ld_q[5:0];

	// schedule extension and round logic
	assign sig0  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign sig1  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new = w_q[0] + sig0 + w_q[9] + sig1;
	assign wt    = w_q[0];
	assign e     = v_q[4];
	assign a     = v_q[0];
	assign t1    = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
		+ ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(rnd_q) + wt;
	assign t2    = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
		+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q <= C_IDLE;
			ld_q  <= '0;
			rnd_q <= '0;
			clr_q <= 1'b1;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (cst_q)
				C_IDLE: begin
					if (ctl.start) begin
						cst_q <= C_LOAD;
						ld_q  <= '0;
					end
				end
				C_LOAD: begin
					ld_q <= ld_q + 7'd1;
					if (ld_q == 7'(BlockBytes)) begin
						cst_q <= C_RUN;
						rnd_q <= '0;
					end
				end
				C_RUN: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(Rounds - 1))
						cst_q <= C_FOLD;
				end
				C_FOLD: begin
					cst_q <= C_IDLE;
					done  <= 1'b1;
					clr_q <= ctl.is_final;
				end
				default: cst_q <= C_IDLE;
			endcase
			if (cst_q == C_IDLE && ctl.start)
				clr_q <= clr_q;
		end
	end

	// schedule window, working vars and chaining words
	always_ff @(posedge clk) begin
		case (cst_q)
			C_IDLE: begin
				if (ctl.start)
					for (int i = 0; i < 8; i++)
						if (clr_q)
							h_q[i] <= init_h(3'(i));
			end
			C_LOAD: begin
				if (ld_q != 7'd0) begin
					for (int i = 0; i < 15; i++)
						w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
					w_q[15] <= {w_q[15][23:0], rd_data_q};
				end
				for (int i = 0; i < 8; i++)
					v_q[i] <= h_q[i];
			end
			C_RUN: begin
				for (int i = 0; i < 15; i++)
					w_q[i] <= w_q[i + 1];
				w_q[15] <= w_new;
				v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			C_FOLD: begin
				for (int i = 0; i < 8; i++)
					h_q[i] <= h_q[i] + v_q[i];
			end
			default: ;
		endcase
	end

	assign busy = (cst_q != C_IDLE);
	always_comb
		for (int i = 0; i < 8; i++)
			hash[255 - 32 * i -: 32] = h_q[i];
endmodule

// ===== rtl/sha256_byte_stream_hash.sv =====
// sha-256 over a byte stream, top level: input control, padding, digest output
// depends on sha_pkg, sha_core
//
// channel | dir | tdata                     | tuser      | tlast
// s_axis  | in  | data_byte[7:0]            | kind       | -
// m_axis  | out | digest_word[31:0], index  | -          | last
//
// a data byte is taken whenever tready is high; every 64th byte holds tready low while
// the block is compressed: a start, the load of the byte buffer one byte a cycle, the
// rounds in the shared round unit, a fold and the done pulse.
// an end transaction writes padding one byte a cycle, runs one or two compressions,
// then sends eight words.
// reset clears control and the next start reloads the initial hash; m_axis stalls hold output.
module sha256_byte_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic        s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zeros
	output logic        m_axis_tlast    // last
);
	import sha_pkg::*;

	state_t       st_q, st_d;
	logic [5:0]   pos_q;
	logic [63:0]  bitlen_q;
	logic         final_q;
	logic [2:0]   widx_q;
	logic [255:0] hash;
	logic         busy, done;
	logic         wr_en;
	logic [5:0]   wr_addr;
	logic [7:0]   wr_data;
	comp_ctl_t    ctl;
	logic         acc;

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.ctl(ctl), .busy(busy), .done(done), .hash(hash)
	);

	assign s_axis_tready = (st_q == ST_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready;

	// next state and buffer writes
	always_comb begin
		st_d         = st_q;
		wr_en        = 1'b0;
		wr_addr      = pos_q;
		wr_data      = s_axis_tdata;
		ctl.start    = 1'b0;
		ctl.is_final = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (acc) begin
					wr_en = 1'b1;
					if (s_axis_tuser) begin
						wr_data = 8'h80;
						st_d = (pos_q == 6'd63) ? ST_LOAD : ST_PAD;
					end else if (pos_q == 6'd63) begin
						st_d = ST_LOAD;
					end
				end
			end
			ST_PAD: begin
				wr_en   = 1'b1;
				wr_data = 8'h00;
				if (pos_q == 6'd63)
					st_d = ST_LOAD;
				else if (pos_q == 6'd56 && final_q) begin
					wr_data = bitlen_q[63:56];
					st_d = ST_LEN;
				end
			end
			ST_LEN: begin
				wr_en   = 1'b1;
				wr_data = bitlen_q[63 - 8 * (pos_q[2:0]) -: 8];
				if (pos_q == 6'd63)
					st_d = ST_LOAD;
			end
			ST_LOAD: begin
				ctl.start = 1'b1;
				st_d = ST_ROUND;
			end
			ST_ROUND: begin
				ctl.is_final = final_q;
				if (done)
					st_d = final_q ? ST_EMIT : (bitlen_q[0] ? ST_PAD : ST_IDLE);
			end
			ST_EMIT: begin
				if (m_axis_tready && widx_q == 3'd7)
					st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// state register and counters; bitlen_q[0] flags a pending padding block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			pos_q    <= '0;
			bitlen_q <= '0;
			final_q  <= 1'b0;
			widx_q   <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						pos_q <= pos_q + 6'd1;
						if (s_axis_tuser) begin
							final_q <= (pos_q < 6'd56);
							bitlen_q[0] <= (pos_q >= 6'd56);
						end else
							bitlen_q <= bitlen_q + 64'd8;
					end
				end
				ST_PAD: begin
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd56 && final_q)
						bitlen_q[0] <= 1'b0;
				end
				ST_LEN: pos_q <= pos_q + 6'd1;
				ST_ROUND: begin
					if (done && !final_q && bitlen_q[0])
						final_q <= 1'b1;
				end
				ST_EMIT: begin
					if (m_axis_tready) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == 3'd7) begin
							pos_q    <= '0;
							bitlen_q <= '0;
							final_q  <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = (st_q == ST_EMIT);
	assign m_axis_tdata  = {5'd0, widx_q, hash[255 - 32 * widx_q -: 32]};
	assign m_axis_tlast  = (widx_q == 3'd7);

`ifndef SYNTHESIS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !busy) else $error("input taken while compressing");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !busy) else $error("digest sent while compressing");
	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> widx_q == 3'd0)
		else $error("word index did not wrap");
`endif
endmodule
